>>> hw/rtl/cpem_pkg.sv
// Shared types and constants for the capture period encoder monitor.
// Holds the transaction payload structs, the lane control struct and register indexes.
// No dependencies.
package cpem_pkg;

  localparam int CHANNELS_DEF     = 2;
  localparam int TICKS_PER_MS_DEF = 4;

  localparam int STAMP_W    = 16;
  localparam int PERIOD_W   = 17;
  localparam int COUNT_W    = 32;
  localparam int TICK_W     = 32;
  localparam int TIMEOUT_W  = 8;
  localparam int TPM_W      = 16;
  localparam int LIMIT_W    = TIMEOUT_W + TPM_W;
  localparam int MASK_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_SECOND = CFG_IDX_W'(1);

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic               channel;
    logic [STAMP_W-1:0] stamp;
    logic               forward;
    logic [TICK_W-1:0]  tick_now;
  } item_t;

  typedef struct packed {
    logic                       out_channel;
    logic [PERIOD_W-1:0]        period;
    logic signed [COUNT_W-1:0]  encoder_count;
    logic [MASK_W-1:0]          cleared_mask;
  } result_t;

  typedef struct packed {
    logic apply;
    logic capture;
    logic update;
    logic hit;
    logic forward;
  } lane_ctl_t;

endpackage

>>> hw/rtl/cpem_lane.sv
// One capture channel: last stamp, period, elapsed ticks and encoder count.
// Computes the next state for a capture or an update sweep and commits it on apply.
// Depends on cpem_pkg.
module cpem_lane #(
  parameter int TICKS_PER_MS = cpem_pkg::TICKS_PER_MS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cpem_pkg::lane_ctl_t               ctl,
  input  logic [cpem_pkg::STAMP_W-1:0]      stamp,
  input  logic [cpem_pkg::TICK_W-1:0]       delta,
  input  logic [cpem_pkg::TIMEOUT_W-1:0]    timeout,
  output logic [cpem_pkg::PERIOD_W-1:0]     period_next,
  output logic [cpem_pkg::COUNT_W-1:0]      count_next,
  output logic                              fired
);
  import cpem_pkg::*;

  logic [STAMP_W-1:0]  last_stamp;
  logic [PERIOD_W-1:0] period;
  logic [TICK_W-1:0]   elapsed;
  logic [COUNT_W-1:0]  count;

  logic [STAMP_W-1:0]  diff;
  logic [PERIOD_W-1:0] cap_period;
  logic [TICK_W:0]     sum;
  logic [TICK_W-1:0]   sat;
  logic [LIMIT_W-1:0]  limit;
  logic [TICK_W-1:0]   elapsed_next;
  logic                do_capture;
  logic                do_update;

  assign do_capture = ctl.apply && ctl.capture && ctl.hit;
  assign do_update  = ctl.apply && ctl.update;

  assign diff       = stamp - last_stamp;
  assign cap_period = (diff == '0) ? {1'b1, {STAMP_W{1'b0}}} : {1'b0, diff};

  assign sum   = {1'b0, elapsed} + {1'b0, delta};
  assign sat   = sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];
  assign limit = LIMIT_W'(timeout) * LIMIT_W'(TPM_W'(TICKS_PER_MS));
  assign fired = ctl.update && (TICK_W'(limit) < sat);

  always_comb begin
    period_next  = period;
    count_next   = count;
    elapsed_next = elapsed;
    if (do_capture) begin
      period_next  = cap_period;
      elapsed_next = '0;
      count_next   = ctl.forward ? count + COUNT_W'(1) : count - COUNT_W'(1);
    end else if (do_update) begin
      period_next  = fired ? '0 : period;
      elapsed_next = fired ? '0 : sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp <= '0;
      period     <= '0;
      elapsed    <= '0;
      count      <= '0;
    end else begin
      if (do_capture) begin
        last_stamp <= stamp;
      end
      period  <= period_next;
      elapsed <= elapsed_next;
      count   <= count_next;
    end
  end

endmodule

>>> hw/rtl/capture_period_encoder_monitor_unit.sv
// Top level of the capture period encoder monitor.
// Holds the input register, timeout registers, channel lanes and the result register.
// Depends on cpem_pkg and cpem_lane.
//
// Takes one transaction per clock while no stalled result holds the input register,
// and returns one result per transaction, passed through the input register, then the
// result register. A capture updates the addressed channel's period, stamp and encoder
// count; an update sweeps all channels at once, each lane with its own adder and
// timeout compare. Channel state commits when a transaction moves from the input
// register into the result register, so a stalled result holds the input register
// but never reorders state updates. Only channels 0 and 1 have timeout registers and
// appear in cleared_mask, the others use a timeout of zero.
module capture_period_encoder_monitor_unit #(
  parameter int CHANNELS     = cpem_pkg::CHANNELS_DEF,
  parameter int TICKS_PER_MS = cpem_pkg::TICKS_PER_MS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  cpem_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output cpem_pkg::result_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cpem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpem_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cpem_pkg::*;

  logic                 stage_valid;
  item_t                stage;
  logic                 advance;
  result_t              result_next;

  logic [TIMEOUT_W-1:0] timeout_first;
  logic [TIMEOUT_W-1:0] timeout_second;
  logic [TICK_W-1:0]    last_tick;
  logic [TICK_W-1:0]    delta;

  logic [PERIOD_W-1:0]  lane_period [CHANNELS];
  logic [COUNT_W-1:0]   lane_count  [CHANNELS];
  logic [CHANNELS-1:0]  lane_fired;

  logic [PERIOD_W-1:0]  period_rd [MASK_W];
  logic [COUNT_W-1:0]   count_rd  [MASK_W];
  logic [MASK_W-1:0]    mask;

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;
  assign cfg_ready  = 1'b1;
  assign delta      = stage.tick_now - last_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_first  <= '0;
      timeout_second <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIMEOUT_FIRST:  timeout_first  <= cfg_data;
        REG_TIMEOUT_SECOND: timeout_second <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    lane_ctl_t            ctl;
    logic [TIMEOUT_W-1:0] lane_timeout;

    if (i == 0) begin : g_first
      assign lane_timeout = timeout_first;
    end else if (i == 1) begin : g_second
      assign lane_timeout = timeout_second;
    end else begin : g_none
      assign lane_timeout = '0;
    end

    assign ctl.apply   = advance;
    assign ctl.capture = (stage.operation == OP_CAPTURE);
    assign ctl.update  = (stage.operation == OP_UPDATE);
    assign ctl.hit     = (int'(stage.channel) == i);
    assign ctl.forward = stage.forward;

    cpem_lane #(
      .TICKS_PER_MS(TICKS_PER_MS)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .stamp      (stage.stamp),
      .delta      (delta),
      .timeout    (lane_timeout),
      .period_next(lane_period[i]),
      .count_next (lane_count[i]),
      .fired      (lane_fired[i])
    );
  end

  for (genvar j = 0; j < MASK_W; j++) begin : g_rd
    if (j < CHANNELS) begin : g_live
      assign period_rd[j] = lane_period[j];
      assign count_rd[j]  = lane_count[j];
      assign mask[j]      = lane_fired[j];
    end else begin : g_absent
      assign period_rd[j] = '0;
      assign count_rd[j]  = '0;
      assign mask[j]      = 1'b0;
    end
  end

  always_comb begin
    result_next.out_channel   = stage.channel;
    result_next.period        = period_rd[stage.channel];
    result_next.encoder_count = count_rd[stage.channel];
    result_next.cleared_mask  = (stage.operation == OP_UPDATE) ? mask : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
      last_tick    <= '0;
    end else begin
      if (item_ready) begin
        stage_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (advance && stage.operation == OP_UPDATE) begin
        last_tick <= stage.tick_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage <= item;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  a_capture_period_nonzero: assert property (@(posedge clk) disable iff (rst)
    (advance && stage.operation == OP_CAPTURE && int'(stage.channel) < CHANNELS)
    |=> (result.period != '0))
    else $error("capture on a live channel reported a zero period");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (stage_valid && result_valid && !result_ready))
    else $error("input stalled without a held result");

  a_cleared_reports_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.cleared_mask[result.out_channel]) |-> (result.period == '0))
    else $error("timed-out channel reported a nonzero period");

endmodule

>>> bench/capture_period_encoder_monitor_unit_tb.sv
// Testbench for capture_period_encoder_monitor_unit: a directed table, then random
// captures and update sweeps, checked against table values or a channel-state predictor.
// Depends on cpem_pkg and the capture_period_encoder_monitor_unit RTL.
module capture_period_encoder_monitor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpem_pkg::*;

  localparam int LONG_HOLD     = 80;
  localparam int STALL_LIMIT   = 2000;
  localparam int SEGMENT_ITEMS = 210;
  localparam int MAX_REPORTS   = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(3);

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    item_t                 it;
    logic                  typed;
    result_t               want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [STAMP_W-1:0]   stamp_mem   [CHANNELS_DEF];
  logic [PERIOD_W-1:0]  period_mem  [CHANNELS_DEF];
  logic [TICK_W-1:0]    elapsed_mem [CHANNELS_DEF];
  logic [COUNT_W-1:0]   count_mem   [CHANNELS_DEF];
  logic [TIMEOUT_W-1:0] timeout_mem [CHANNELS_DEF];
  logic [TICK_W-1:0]    tick_mem;

  result_t pending_reports[$];
  row_t    stim_table[$];
  int      fault_count = 0;
  int      quiet_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  logic    long_hold_armed = 1'b0;
  int      long_hold_count = 0;

  capture_period_encoder_monitor_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t advance_channels(input item_t it);
    result_t            r;
    logic [STAMP_W-1:0] diff;
    logic [TICK_W-1:0]  delta;
    logic [TICK_W:0]    sum;
    logic [TICK_W:0]    limit;
    logic [MASK_W-1:0]  mask;
    mask = '0;
    if (it.operation == OP_CAPTURE) begin
      diff = it.stamp - stamp_mem[it.channel];
      period_mem[it.channel] = (diff == '0) ? PERIOD_W'(1 << STAMP_W) : PERIOD_W'(diff);
      stamp_mem[it.channel] = it.stamp;
      elapsed_mem[it.channel] = '0;
      count_mem[it.channel] = it.forward ? count_mem[it.channel] + COUNT_W'(1)
                                         : count_mem[it.channel] - COUNT_W'(1);
    end else begin
      delta = it.tick_now - tick_mem;
      for (int i = 0; i < CHANNELS_DEF; i++) begin
        sum = {1'b0, elapsed_mem[i]} + {1'b0, delta};
        if (sum[TICK_W]) sum = {1'b0, {TICK_W{1'b1}}};
        elapsed_mem[i] = sum[TICK_W-1:0];
        limit = (TICK_W+1)'(timeout_mem[i]) * (TICK_W+1)'(TICKS_PER_MS_DEF);
        if (limit < sum) begin
          period_mem[i] = '0;
          elapsed_mem[i] = '0;
          if (i < MASK_W) mask[i] = 1'b1;
        end
      end
      tick_mem = it.tick_now;
    end
    r.out_channel   = it.channel;
    r.period        = period_mem[it.channel];
    r.encoder_count = count_mem[it.channel];
    r.cleared_mask  = mask;
    return r;
  endfunction

  function automatic row_t capture_row(input logic ch, input logic [STAMP_W-1:0] stamp,
                                       input logic fwd);
    row_t r;
    r = '0;
    r.it.operation = OP_CAPTURE;
    r.it.channel   = ch;
    r.it.stamp     = stamp;
    r.it.forward   = fwd;
    return r;
  endfunction

  function automatic row_t update_row(input logic ch, input logic [TICK_W-1:0] tick);
    row_t r;
    r = '0;
    r.it.operation = OP_UPDATE;
    r.it.channel   = ch;
    r.it.tick_now  = tick;
    return r;
  endfunction

  function automatic row_t register_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '0;
    r.is_cfg    = 1'b1;
    r.cfg_index = idx;
    r.cfg_data  = data;
    return r;
  endfunction

  function automatic row_t with_result(input row_t r, input logic [PERIOD_W-1:0] period,
                                       input logic [COUNT_W-1:0] count,
                                       input logic [MASK_W-1:0] mask);
    row_t t;
    t = r;
    t.typed              = 1'b1;
    t.want.out_channel   = r.it.channel;
    t.want.period        = period;
    t.want.encoder_count = count;
    t.want.cleared_mask  = mask;
    return t;
  endfunction

  function automatic item_t draw_item();
    item_t it;
    int    pick;
    it.operation = ($urandom_range(0, 9) < 6) ? OP_CAPTURE : OP_UPDATE;
    it.channel   = 1'($urandom_range(0, 1));
    it.forward   = 1'($urandom_range(0, 1));
    it.stamp     = STAMP_W'($urandom);
    it.tick_now  = TICK_W'($urandom);
    if (it.operation == OP_CAPTURE) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) it.stamp = stamp_mem[it.channel];
      else if (pick > 2) it.stamp = stamp_mem[it.channel] + STAMP_W'($urandom_range(1, 4000));
    end else begin
      pick = $urandom_range(0, 15);
      if (pick == 0) it.tick_now = tick_mem - TICK_W'(1);
      else if (pick < 3) it.tick_now = tick_mem + TICK_W'($urandom_range(1000, 1100));
      else if (pick < 14) it.tick_now = tick_mem + TICK_W'($urandom_range(0, 400));
    end
    return it;
  endfunction

  task automatic offer_item(input item_t it, input logic typed, input result_t want);
    result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    do @(posedge clk); while (!item_ready);
    predicted = advance_channels(it);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  // Hold off new transactions until every result is back and the pipeline is empty.
  task automatic settle_pipeline();
    @(negedge clk);
    item_valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    settle_pipeline();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TIMEOUT_FIRST) timeout_mem[0] = data;
    else if (idx == REG_TIMEOUT_SECOND) timeout_mem[1] = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic note_fault(input string what, input result_t want);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t: %s: got ch=%0d per=%0d cnt=%0d mask=%b, want ch=%0d per=%0d cnt=%0d mask=%b",
               $realtime, what, result.out_channel, result.period, result.encoder_count,
               result.cleared_mask, want.out_channel, want.period, want.encoder_count,
               want.cleared_mask);
  endtask

  always @(negedge clk) begin
    if (long_hold_armed && long_hold_count < LONG_HOLD) begin
      result_ready = 1'b0;
      long_hold_count++;
    end else begin
      result_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_reports.size() == 0) begin
        note_fault("result with nothing pending", '0);
      end else begin
        want = pending_reports.pop_front();
        if (result.out_channel !== want.out_channel || result.period !== want.period ||
            result.encoder_count !== want.encoder_count ||
            result.cleared_mask !== want.cleared_mask)
          note_fault("mismatch", want);
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int first;
    int second;
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      stamp_mem[i]   = '0;
      period_mem[i]  = '0;
      elapsed_mem[i] = '0;
      count_mem[i]   = '0;
      timeout_mem[i] = '0;
    end
    tick_mem = '0;

    // zero diff wraps, timeout zero fires on any nonzero elapsed time, equal-to-limit holds,
    // saturation of elapsed ticks, unmapped register index
    stim_table.push_back(with_result(capture_row(1'b0, 16'h0000, 1'b1),
                                     17'h10000, 32'h0000_0001, 2'b00));
    stim_table.push_back(with_result(capture_row(1'b1, 16'hFFFF, 1'b0),
                                     17'h0FFFF, 32'hFFFF_FFFF, 2'b00));
    stim_table.push_back(with_result(capture_row(1'b1, 16'hFFFF, 1'b0),
                                     17'h10000, 32'hFFFF_FFFE, 2'b00));
    stim_table.push_back(with_result(capture_row(1'b0, 16'h0001, 1'b1),
                                     17'h00001, 32'h0000_0002, 2'b00));
    stim_table.push_back(with_result(update_row(1'b0, 32'd0), 17'd1, 32'h0000_0002, 2'b00));
    stim_table.push_back(with_result(update_row(1'b1, 32'd1), 17'd0, 32'hFFFF_FFFE, 2'b11));
    stim_table.push_back(with_result(update_row(1'b1, 32'd1), 17'd0, 32'hFFFF_FFFE, 2'b00));
    stim_table.push_back(with_result(update_row(1'b0, 32'd2), 17'd0, 32'h0000_0002, 2'b11));
    stim_table.push_back(register_row(REG_TIMEOUT_FIRST, 8'hFF));
    stim_table.push_back(register_row(REG_TIMEOUT_SECOND, 8'h01));
    stim_table.push_back(register_row(REG_UNMAPPED, 8'h00));
    stim_table.push_back(capture_row(1'b0, 16'h8000, 1'b1));
    stim_table.push_back(with_result(update_row(1'b0, 32'd6), 17'd32767, 32'h0000_0003, 2'b00));
    stim_table.push_back(with_result(update_row(1'b1, 32'd7), 17'd0, 32'hFFFF_FFFE, 2'b10));
    stim_table.push_back(with_result(update_row(1'b0, 32'd1022),
                                     17'd32767, 32'h0000_0003, 2'b10));
    stim_table.push_back(with_result(update_row(1'b0, 32'd1021), 17'd0, 32'h0000_0003, 2'b11));
    stim_table.push_back(update_row(1'b1, 32'hFFFF_FFFF));
    stim_table.push_back(with_result(capture_row(1'b1, 16'hFFFF, 1'b1),
                                     17'h10000, 32'hFFFF_FFFF, 2'b00));
    stim_table.push_back(with_result(capture_row(1'b1, 16'h0000, 1'b1),
                                     17'd1, 32'h0000_0000, 2'b00));
    stim_table.push_back(capture_row(1'b0, 16'h7FFF, 1'b0));
    stim_table.push_back(update_row(1'b0, 32'h8000_0000));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_table[n]) begin
      if (stim_table[n].is_cfg)
        write_register(stim_table[n].cfg_index, stim_table[n].cfg_data);
      else
        offer_item(stim_table[n].it, stim_table[n].typed, stim_table[n].want);
    end

    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin
          send_idle_pct = 31; recv_idle_pct = 68; first = 255; second = 0;
        end
        1: begin
          send_idle_pct = 68; recv_idle_pct = 31; first = 0; second = 255;
        end
        2: begin
          send_idle_pct = 0; recv_idle_pct = 0; first = 255; second = 255;
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0;
          first = $urandom_range(0, 255); second = $urandom_range(0, 255);
        end
      endcase
      write_register(REG_TIMEOUT_FIRST, CFG_DATA_W'(first));
      write_register(REG_TIMEOUT_SECOND, CFG_DATA_W'(second));
      write_register(CFG_IDX_W'($urandom_range(REG_TIMEOUT_SECOND + 1, REG_UNMAPPED)),
                     CFG_DATA_W'($urandom));
      if (seg == 3) long_hold_armed = 1'b1;
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        if (seg == 2 && k == SEGMENT_ITEMS / 2) settle_pipeline();
        offer_item(draw_item(), 1'b0, '0);
      end
    end

    settle_pipeline();
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/cpem_pkg.sv
hw/rtl/cpem_lane.sv
hw/rtl/capture_period_encoder_monitor_unit.sv
bench/capture_period_encoder_monitor_unit_tb.sv
